>>> hw/rtl/telnet_receive_negotiator_assert.svh
// Assertion macros for the telnet receive negotiator RTL.
`ifndef TELNET_RECEIVE_NEGOTIATOR_ASSERT_SVH
`define TELNET_RECEIVE_NEGOTIATOR_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define TRN_ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("trn assertion failed");

// Next-cycle implication, disabled while reset is high.
`define TRN_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("trn assertion failed");

`endif

>>> hw/rtl/trn_pkg.sv
// Shared types and constants of the telnet receive negotiator.
package trn_pkg;

  // Telnet command codes.
  localparam logic [7:0] CmdIac  = 8'd255;
  localparam logic [7:0] CmdDont = 8'd254;
  localparam logic [7:0] CmdDo   = 8'd253;
  localparam logic [7:0] CmdWont = 8'd252;
  localparam logic [7:0] CmdWill = 8'd251;
  localparam logic [7:0] CmdSb   = 8'd250;
  localparam logic [7:0] CmdGa   = 8'd249;
  localparam logic [7:0] CmdSe   = 8'd240;
  localparam logic [7:0] CmdEor  = 8'd239;

  // Option codes.
  localparam logic [7:0] OptBinary   = 8'd0;
  localparam logic [7:0] OptEor      = 8'd25;
  localparam logic [7:0] OptStartTls = 8'd46;

  // Default depth of the queue between parser and result stage.
  localparam int QueueDepth = 4;

  // Parser phase.
  typedef enum logic [1:0] {
    PH_NORMAL = 2'd0,
    PH_IAC    = 2'd1,
    PH_OPTION = 2'd2
  } phase_t;

  // Operation kinds; the encoding equals the result kind on the output.
  typedef enum logic [1:0] {
    OP_DATA     = 2'd0,
    OP_REPLY    = 2'd1,
    OP_TLS      = 2'd2,
    OP_SB_CLOSE = 2'd3
  } op_kind_t;

  // Reply verbs.
  typedef enum logic [1:0] {
    VERB_WILL = 2'd0,
    VERB_WONT = 2'd1,
    VERB_DO   = 2'd2,
    VERB_DONT = 2'd3
  } verb_t;

  // One classified operation as queued between the parser and the result stage.
  typedef struct packed {
    op_kind_t   kind;
    logic [7:0] value;
    verb_t      verb;
  } neg_op_t;

  // Queue status seen by its neighbors.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

>>> hw/rtl/trn_if.sv
// Channel interfaces of the telnet receive negotiator.

// Received byte channel.
interface trn_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// Result channel.
interface trn_res_if;
  logic       valid;
  logic       ready;
  logic [1:0] result_kind;
  logic [7:0] data_byte;
  logic [1:0] reply_verb;
  logic [7:0] reply_option;
  logic       link_up;

  modport source (output valid, output result_kind, output data_byte, output reply_verb,
                  output reply_option, output link_up, input ready);
  modport sink (input valid, input result_kind, input data_byte, input reply_verb,
                input reply_option, input link_up, output ready);
endinterface

// Configuration write channel.
interface trn_cfg_if;
  logic valid;
  logic ready;
  logic tls_offer_enabled;

  modport source (output valid, output tls_offer_enabled, input ready);
  modport sink (input valid, input tls_offer_enabled, output ready);
endinterface

>>> hw/rtl/trn_front.sv
// Front parser: tracks the IAC phase machine and classifies each received byte.
module trn_front (
  input  logic                   clk,
  input  logic                   rst,
  trn_rx_if.sink                 rx,
  input  trn_pkg::queue_status_t qstat,
  output logic                   push,
  output trn_pkg::neg_op_t       op
);

  trn_pkg::phase_t phase, phase_next;
  logic [7:0]      pending_command, pending_command_next;
  logic            in_sub, in_sub_next;
  logic [7:0]      sub_option, sub_option_next;
  logic            accept;
  logic            has_op;

  // A byte is taken whenever the queue has room for its possible operation.
  assign rx.ready = !qstat.full;
  assign accept   = rx.valid && rx.ready;
  assign push     = accept && has_op;

  // Parser state registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase           <= trn_pkg::PH_NORMAL;
      pending_command <= '0;
      in_sub          <= 1'b0;
      sub_option      <= trn_pkg::OptBinary;
    end else if (accept) begin
      phase           <= phase_next;
      pending_command <= pending_command_next;
      in_sub          <= in_sub_next;
      sub_option      <= sub_option_next;
    end
  end

  // Next phase and classification of the current byte.
  always_comb begin
    phase_next           = trn_pkg::PH_NORMAL;
    pending_command_next = pending_command;
    in_sub_next          = in_sub;
    sub_option_next      = sub_option;
    has_op               = 1'b0;
    op.kind              = trn_pkg::OP_DATA;
    op.value             = rx.rx_byte;
    op.verb              = trn_pkg::VERB_WILL;
    unique case (phase)
      trn_pkg::PH_IAC: begin
        if (rx.rx_byte == trn_pkg::CmdIac) begin
          // Escaped 255 is data, or dropped payload inside a subnegotiation.
          has_op = !in_sub;
        end else if (rx.rx_byte inside {[trn_pkg::CmdEor:trn_pkg::CmdGa]}) begin
          // Standalone command; only SE inside a subnegotiation acts.
          if (rx.rx_byte == trn_pkg::CmdSe && in_sub) begin
            in_sub_next = 1'b0;
            has_op      = 1'b1;
            op.kind     = trn_pkg::OP_SB_CLOSE;
            op.value    = sub_option;
          end
        end else begin
          pending_command_next = rx.rx_byte;
          phase_next           = trn_pkg::PH_OPTION;
        end
      end
      trn_pkg::PH_OPTION: begin
        if (pending_command == trn_pkg::CmdWill) begin
          has_op = 1'b1;
          if (rx.rx_byte == trn_pkg::OptBinary || rx.rx_byte == trn_pkg::OptEor) begin
            op.kind = trn_pkg::OP_REPLY;
            op.verb = trn_pkg::VERB_DO;
          end else if (rx.rx_byte == trn_pkg::OptStartTls) begin
            op.kind = trn_pkg::OP_TLS;
          end else begin
            op.kind = trn_pkg::OP_REPLY;
            op.verb = trn_pkg::VERB_DONT;
          end
        end else if (pending_command == trn_pkg::CmdDo) begin
          has_op  = 1'b1;
          op.kind = trn_pkg::OP_REPLY;
          if (rx.rx_byte == trn_pkg::OptBinary || rx.rx_byte == trn_pkg::OptEor) begin
            op.verb = trn_pkg::VERB_WILL;
          end else begin
            op.verb = trn_pkg::VERB_WONT;
          end
        end else if (pending_command == trn_pkg::CmdSb) begin
          in_sub_next     = 1'b1;
          sub_option_next = rx.rx_byte;
        end
      end
      default: begin
        // Normal phase: IAC opens a command, other bytes are data unless inside a subnegotiation.
        if (rx.rx_byte == trn_pkg::CmdIac) begin
          phase_next = trn_pkg::PH_IAC;
        end else begin
          has_op = !in_sub;
        end
      end
    endcase
  end

endmodule

>>> hw/rtl/trn_queue.sv
// Short FIFO of classified operations between the parser and the result stage.
module trn_queue #(
  parameter int Depth = trn_pkg::QueueDepth
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  trn_pkg::neg_op_t       push_op,
  input  logic                   pop,
  output trn_pkg::neg_op_t       head_op,
  output trn_pkg::queue_status_t qstat
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);

  trn_pkg::neg_op_t entries [Depth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntW-1:0]  count;
  logic             do_push;
  logic             do_pop;

  assign qstat.full  = (count == CntW'(Depth));
  assign qstat.empty = (count == '0);
  assign do_push     = push && !qstat.full;
  assign do_pop      = pop && !qstat.empty;
  assign head_op     = entries[rd_ptr];

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_op;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(Depth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(Depth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

>>> hw/rtl/trn_back.sv
// Result stage: turns queued operations into result transactions.
module trn_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   tls_offer_enabled,
  input  trn_pkg::neg_op_t       head_op,
  input  trn_pkg::queue_status_t qstat,
  output logic                   pop,
  trn_res_if.source              result
);

  logic             out_valid;
  logic             handshake_done;
  logic             load;
  logic [1:0]       kind_q;
  logic [7:0]       data_q;
  logic [1:0]       verb_q;
  logic [7:0]       option_q;
  logic             link_up_q;

  // Take the head whenever the output register is free or being emptied.
  assign pop  = !qstat.empty && (!out_valid || result.ready);
  // A start-TLS offer is dropped unless offers are enabled.
  assign load = pop && !(head_op.kind == trn_pkg::OP_TLS && !tls_offer_enabled);

  // Control: output valid and the link-up flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      handshake_done <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
      if (load && head_op.kind == trn_pkg::OP_DATA) begin
        handshake_done <= 1'b1;
      end
    end
  end

  // Result payload; fields that do not belong to the kind read as zero.
  always_ff @(posedge clk) begin
    if (load) begin
      kind_q    <= head_op.kind;
      data_q    <= (head_op.kind == trn_pkg::OP_DATA) ? head_op.value : 8'd0;
      verb_q    <= (head_op.kind == trn_pkg::OP_REPLY) ? head_op.verb : trn_pkg::VERB_WILL;
      option_q  <= (head_op.kind == trn_pkg::OP_DATA) ? 8'd0 :
                   (head_op.kind == trn_pkg::OP_TLS)  ? trn_pkg::OptStartTls :
                                                        head_op.value;
      link_up_q <= (head_op.kind == trn_pkg::OP_DATA) && !handshake_done;
    end
  end

  assign result.valid        = out_valid;
  assign result.result_kind  = kind_q;
  assign result.data_byte    = data_q;
  assign result.reply_verb   = verb_q;
  assign result.reply_option = option_q;
  assign result.link_up      = link_up_q;

endmodule

>>> hw/rtl/telnet_receive_negotiator.sv
// Telnet receive negotiator top level: parser, operation queue and result stage.
// Takes one received telnet byte per cycle on rx when ready and gives at most one result
// per byte on result. The parser's phase machine handles one byte each cycle unless the
// queue is full; the result stage delivers one result each cycle while result is ready.
// The queue holds QueueDepth operations, so rx stays ready until that many results wait
// behind a stalled result channel. The configuration channel is always ready and its
// write takes effect on the next cycle; write it only while no bytes are in flight.
`include "telnet_receive_negotiator_assert.svh"

module telnet_receive_negotiator #(
  parameter int QueueDepth = trn_pkg::QueueDepth
) (
  input  logic      clk,
  input  logic      rst,
  trn_rx_if.sink    rx,
  trn_res_if.source result,
  trn_cfg_if.sink   cfg
);

  logic                   tls_offer_enabled;
  logic                   push;
  logic                   pop;
  trn_pkg::neg_op_t       push_op;
  trn_pkg::neg_op_t       head_op;
  trn_pkg::queue_status_t qstat;

  // Configuration register.
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      tls_offer_enabled <= 1'b0;
    end else if (cfg.valid && cfg.ready) begin
      tls_offer_enabled <= cfg.tls_offer_enabled;
    end
  end

  // Parser.
  trn_front u_front (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx),
    .qstat (qstat),
    .push  (push),
    .op    (push_op)
  );

  // Operation queue.
  trn_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_op (push_op),
    .pop     (pop),
    .head_op (head_op),
    .qstat   (qstat)
  );

  // Result stage.
  trn_back u_back (
    .clk               (clk),
    .rst               (rst),
    .tls_offer_enabled (tls_offer_enabled),
    .head_op           (head_op),
    .qstat             (qstat),
    .pop               (pop),
    .result            (result)
  );

  // The parser never pushes into a full queue.
  `TRN_ASSERT_IMPL(a_no_push_when_full, clk, rst, push, !qstat.full)
  // A start-TLS request only leaves while offers are enabled.
  `TRN_ASSERT_IMPL(a_tls_only_enabled, clk, rst,
                   result.valid && result.result_kind == trn_pkg::OP_TLS, tls_offer_enabled)
  // Link up is flagged only on a data transaction.
  `TRN_ASSERT_IMPL(a_link_up_data, clk, rst, result.valid && result.link_up,
                   result.result_kind == trn_pkg::OP_DATA && result.reply_option == '0)
  // Once the link-up transaction is taken, the next result does not repeat it.
  `TRN_ASSERT_NEXT(a_link_up_once, clk, rst, result.valid && result.ready && result.link_up,
                   !(result.valid && result.link_up))

endmodule
